FILE: sv/ffl_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the force-field tuple lookup unit
// no dependencies

package ffl_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int ID_W        = 16;
	localparam int ADDR_W      = 6;
	localparam int CNT_W       = 7;
	localparam int NUM_LANES   = 4;

	// opcodes
	localparam logic [1:0] OP_WRITE     = 2'd0;
	localparam logic [1:0] OP_SELECT    = 2'd1;
	localparam logic [1:0] OP_TRANSLATE = 2'd2;
	localparam logic [1:0] OP_NONE      = 2'd3;

	// table selections
	localparam logic [2:0] TBL_ATOM  = 3'd0;
	localparam logic [2:0] TBL_TRANS = 3'd1;
	localparam logic [2:0] TBL_BOND  = 3'd2;
	localparam logic [2:0] TBL_ANGLE = 3'd3;
	localparam logic [2:0] TBL_DIHED = 3'd4;
	localparam logic [2:0] TBL_IMPR  = 3'd5;
	localparam logic [2:0] TBL_INDEX = 3'd6;
	localparam logic [2:0] TBL_BAD   = 3'd7;

	// configuration register indexes
	localparam logic [2:0] REG_ATOM_CNT  = 3'd0;
	localparam logic [2:0] REG_TRANS_CNT = 3'd1;
	localparam logic [2:0] REG_BOND_CNT  = 3'd2;
	localparam logic [2:0] REG_ANGLE_CNT = 3'd3;
	localparam logic [2:0] REG_DIHED_CNT = 3'd4;

	typedef logic [NUM_LANES-1:0][ID_W-1:0] ids_t;

	// control from sequencer to one lane
	typedef struct packed {
		logic       clr;
		logic       en;
		logic [2:0] len;
	} lane_ctl_t;

	// what one lane found
	typedef struct packed {
		logic              hit;
		logic [ADDR_W-1:0] pos;
		logic [ID_W-1:0]   dest;
	} lane_res_t;

endpackage

FILE: sv/ffl_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module ffl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/ffl_lane.sv
`timescale 1ns / 1ps
// one compare lane: matches a key of 1 to 4 ids, forward or reversed,
// against a scanned table entry and keeps the first hit; uses ffl_pkg

module ffl_lane import ffl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lane_ctl_t              ctl,
	input  ids_t                   key,
	input  logic [NUM_LANES*ID_W-1:0] data,
	input  logic [ID_W-1:0]        dest,
	input  logic                   vld,
	input  logic [ADDR_W-1:0]      idx,
	output lane_res_t              res
);

	logic            fwd;
	logic            rev;
	logic            hit_q;
	logic [ADDR_W-1:0] pos_q;
	logic [ID_W-1:0] dest_q;

	// forward and reversed compare over the used slots
	always_comb begin
		logic [1:0] ridx;
		fwd = 1'b1;
		rev = 1'b1;
		for (int k = 0; k < NUM_LANES; k++) begin
			ridx = 2'(ctl.len - 3'(k) - 3'd1);
			if (3'(k) < ctl.len) begin
				if (data[k*ID_W +: ID_W] != key[k]) fwd = 1'b0;
				if (data[k*ID_W +: ID_W] != key[ridx]) rev = 1'b0;
			end
		end
	end

	// first hit capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.clr) begin
			hit_q <= 1'b0;
		end else if (vld && ctl.en && !hit_q && (fwd || rev)) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld && ctl.en && !hit_q && (fwd || rev)) begin
			pos_q  <= idx;
			dest_q <= dest;
		end
	end

	assign res.hit  = hit_q;
	assign res.pos  = pos_q;
	assign res.dest = dest_q;

endmodule

FILE: sv/ffl_merge.sv
`timescale 1ns / 1ps
// merges lane results into one result beat
// uses ffl_pkg

module ffl_merge import ffl_pkg::*; (
	input  logic [1:0]              op,
	input  logic [2:0]              tbl,
	input  ids_t                    ids,
	input  lane_res_t [NUM_LANES-1:0] lanes,
	output logic                    found,
	output logic [ADDR_W-1:0]       pos,
	output logic                    bad,
	output ids_t                    outs
);

	always_comb begin
		found = 1'b0;
		pos   = '0;
		bad   = 1'b0;
		outs  = '0;
		unique case (op)
			OP_WRITE: begin
				bad = (tbl == TBL_BAD);
			end
			OP_SELECT: begin
				unique case (tbl)
					TBL_ATOM, TBL_TRANS, TBL_BOND, TBL_ANGLE, TBL_DIHED: begin
						found = lanes[0].hit;
						pos   = lanes[0].hit ? lanes[0].pos : '0;
					end
					TBL_INDEX: begin
						found = (ids[0][ID_W-1:ADDR_W] == '0);
						pos   = found ? ids[0][ADDR_W-1:0] : '0;
					end
					TBL_BAD: bad = 1'b1;
					default: found = 1'b0;
				endcase
			end
			OP_TRANSLATE: begin
				for (int k = 0; k < NUM_LANES; k++) begin
					outs[k] = lanes[k].hit ? lanes[k].dest : ids[k];
				end
			end
			default: found = 1'b0;
		endcase
	end

endmodule

FILE: sv/force_field_tuple_lookup_unit.sv
`timescale 1ns / 1ps
// top level of the force-field tuple lookup unit
// uses ffl_pkg, ffl_ram, ffl_lane, ffl_merge

// Holds atom, translation, bond, angle and dihedral tables of 64 entries in
// rams and answers one beat per input beat. One beat is worked on at a time.
// Some beats scan no entries: writes, unknown opcodes, impropers, the index
// table and an invalid table; their result passes the scan and finish states
// into the output register. A select or translate beat scans the chosen table
// once, one entry per cycle through the ram read port, over the table's count
// clamped to 64, and loads its result once the last entry read is compared; a
// count of zero scans no entries. Translate runs four compare lanes over the
// translation table in the same scan. The next input beat is accepted from
// the cycle after the result is loaded. A result still waiting in the output
// register holds the next result back until the waiting one is taken.
module force_field_tuple_lookup_unit import ffl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// entry_index, node_a, node_b, node_c, node_d, entry_dest, tuple_len
	input  logic [95:0] s_tdata,
	// opcode, table_select
	input  logic [4:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// match_index, out_a, out_b, out_c, out_d
	output logic [71:0] m_tdata,
	// found, bad_request
	output logic [1:0]  m_tuser,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] atom_cnt_q, trans_cnt_q, bond_cnt_q, angle_cnt_q, dihed_cnt_q;
	logic [1:0]       op_q;
	logic [2:0]       tbl_q;
	ids_t             ids_q;
	logic [2:0]       len_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rd_v_s1;
	logic [ADDR_W-1:0] idx_s1;

	logic [1:0]       in_op;
	logic [2:0]       in_tbl;
	logic [ADDR_W-1:0] in_entry;
	ids_t             in_ids;
	logic [ID_W-1:0]  in_dest;
	logic [2:0]       in_len;
	logic             acc;
	logic [CNT_W-1:0] sel_cnt;
	logic [CNT_W-1:0] sel_n;
	logic             wr_ok;

	logic [ID_W-1:0]   atom_rd;
	logic [2*ID_W-1:0] trans_rd;
	logic [2*ID_W-1:0] bond_rd;
	logic [3*ID_W-1:0] angle_rd;
	logic [4*ID_W-1:0] dihed_rd;

	lane_ctl_t [NUM_LANES-1:0] ctl;
	ids_t      [NUM_LANES-1:0] keys;
	logic      [NUM_LANES*ID_W-1:0] lane0_data;
	logic      [NUM_LANES*ID_W-1:0] trans_data;
	lane_res_t [NUM_LANES-1:0] lres;

	logic             m_found, m_bad;
	logic [ADDR_W-1:0] m_pos;
	ids_t             m_outs;
	logic             out_load;

	// input beat unpacking
	assign in_op    = s_tuser[1:0];
	assign in_tbl   = s_tuser[4:2];
	assign in_entry = s_tdata[5:0];
	assign in_ids   = s_tdata[69:6];
	assign in_dest  = s_tdata[85:70];
	assign in_len   = s_tdata[88:86];

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign out_load = (state_q == ST_FIN) && (!m_tvalid || m_tready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atom_cnt_q  <= '0;
			trans_cnt_q <= '0;
			bond_cnt_q  <= '0;
			angle_cnt_q <= '0;
			dihed_cnt_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ATOM_CNT:  atom_cnt_q  <= cfg_data;
				REG_TRANS_CNT: trans_cnt_q <= cfg_data;
				REG_BOND_CNT:  bond_cnt_q  <= cfg_data;
				REG_ANGLE_CNT: angle_cnt_q <= cfg_data;
				REG_DIHED_CNT: dihed_cnt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// entries to scan for the incoming beat
	always_comb begin
		sel_cnt = '0;
		if (in_op == OP_TRANSLATE) begin
			sel_cnt = trans_cnt_q;
		end else if (in_op == OP_SELECT) begin
			unique case (in_tbl)
				TBL_ATOM:  sel_cnt = atom_cnt_q;
				TBL_TRANS: sel_cnt = trans_cnt_q;
				TBL_BOND:  sel_cnt = bond_cnt_q;
				TBL_ANGLE: sel_cnt = angle_cnt_q;
				TBL_DIHED: sel_cnt = dihed_cnt_q;
				default:   sel_cnt = '0;
			endcase
		end
		sel_n = (sel_cnt > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : sel_cnt;
	end

	assign wr_ok = acc && (in_op == OP_WRITE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_SCAN) && (cnt_q < n_q);
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (acc) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cnt_q < n_q) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!rd_v_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[ADDR_W-1:0];
		if (acc) begin
			op_q  <= in_op;
			tbl_q <= in_tbl;
			ids_q <= in_ids;
			len_q <= in_len;
			n_q   <= sel_n;
		end
	end

	// table storage
	ffl_ram #(.WIDTH(ID_W), .DEPTH(TABLE_DEPTH)) u_atom (
		.clk(clk), .we(wr_ok && in_tbl == TBL_ATOM), .waddr(in_entry),
		.wdata(in_ids[0]), .raddr(cnt_q[ADDR_W-1:0]), .rdata(atom_rd)
	);
	ffl_ram #(.WIDTH(2*ID_W), .DEPTH(TABLE_DEPTH)) u_trans (
		.clk(clk), .we(wr_ok && in_tbl == TBL_TRANS), .waddr(in_entry),
		.wdata({in_dest, in_ids[0]}), .raddr(cnt_q[ADDR_W-1:0]), .rdata(trans_rd)
	);
	ffl_ram #(.WIDTH(2*ID_W), .DEPTH(TABLE_DEPTH)) u_bond (
		.clk(clk), .we(wr_ok && in_tbl == TBL_BOND), .waddr(in_entry),
		.wdata({in_ids[1], in_ids[0]}), .raddr(cnt_q[ADDR_W-1:0]), .rdata(bond_rd)
	);
	ffl_ram #(.WIDTH(3*ID_W), .DEPTH(TABLE_DEPTH)) u_angle (
		.clk(clk), .we(wr_ok && in_tbl == TBL_ANGLE), .waddr(in_entry),
		.wdata({in_ids[2], in_ids[1], in_ids[0]}), .raddr(cnt_q[ADDR_W-1:0]),
		.rdata(angle_rd)
	);
	ffl_ram #(.WIDTH(4*ID_W), .DEPTH(TABLE_DEPTH)) u_dihed (
		.clk(clk), .we(wr_ok && in_tbl == TBL_DIHED), .waddr(in_entry),
		.wdata(in_ids), .raddr(cnt_q[ADDR_W-1:0]), .rdata(dihed_rd)
	);

	// lane inputs
	assign trans_data = {{(3*ID_W){1'b0}}, trans_rd[ID_W-1:0]};

	always_comb begin
		lane0_data = trans_data;
		if (op_q == OP_SELECT) begin
			unique case (tbl_q)
				TBL_ATOM:  lane0_data = {{(3*ID_W){1'b0}}, atom_rd};
				TBL_BOND:  lane0_data = {{(2*ID_W){1'b0}}, bond_rd};
				TBL_ANGLE: lane0_data = {{ID_W{1'b0}}, angle_rd};
				TBL_DIHED: lane0_data = dihed_rd;
				default:   lane0_data = trans_data;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_LANES; k++) begin
			ctl[k].clr = acc;
			ctl[k].en  = (op_q == OP_TRANSLATE) && (len_q > 3'(k));
			ctl[k].len = 3'd1;
			keys[k]    = '0;
			keys[k][0] = ids_q[k];
		end
		if (op_q == OP_SELECT) begin
			ctl[0].en = 1'b1;
			keys[0]   = ids_q;
			unique case (tbl_q)
				TBL_BOND:  ctl[0].len = 3'd2;
				TBL_ANGLE: ctl[0].len = 3'd3;
				TBL_DIHED: ctl[0].len = 3'd4;
				default:   ctl[0].len = 3'd1;
			endcase
		end
	end

	// compare lanes
	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		ffl_lane u_lane (
			.clk(clk), .arst_n(arst_n), .ctl(ctl[g]), .key(keys[g]),
			.data((g == 0) ? lane0_data : trans_data),
			.dest(trans_rd[2*ID_W-1:ID_W]), .vld(rd_v_s1), .idx(idx_s1),
			.res(lres[g])
		);
	end

	ffl_merge u_merge (
		.op(op_q), .tbl(tbl_q), .ids(ids_q), .lanes(lres),
		.found(m_found), .pos(m_pos), .bad(m_bad), .outs(m_outs)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {2'b00, m_outs, m_pos};
			m_tuser <= {m_bad, m_found};
		end
	end

`ifndef NO_ASSERTIONS
	a_rd_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> state_q == ST_SCAN)
		else $error("read data valid outside scan");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> cnt_q <= n_q)
		else $error("scan counter past entry count");
	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> !rd_v_s1)
		else $error("finish with read still in flight");
	a_found_bad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("found and bad request together");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for force_field_tuple_lookup_unit: directed and random
// table writes, lookups and translations checked beat by beat; uses ffl_pkg

module tb_top;
	import ffl_pkg::*;

	typedef struct {
		logic [1:0]  op;
		logic [2:0]  tbl;
		logic [5:0]  idx;
		logic [15:0] node [4];
		logic [15:0] dest;
		logic [2:0]  len;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [5:0]  pos;
		logic        bad;
		logic [15:0] out_d;
		logic [15:0] out_c;
		logic [15:0] out_b;
		logic [15:0] out_a;
	} answer_t;

	// mirror of the tables plus the queue of answers still owed
	class lookup_scoreboard;
		logic [15:0] atom_tab [64];
		logic [15:0] src_tab [64];
		logic [15:0] dst_tab [64];
		logic [63:0] key_tab [5][64];
		int          count [5];
		answer_t     owed [$];
		int          errors;

		function new();
			errors = 0;
			foreach (count[i]) count[i] = 0;
		endfunction

		function void set_count(int r, int v);
			count[r] = v;
		endfunction

		function int limit(int r);
			return (count[r] > TABLE_DEPTH) ? TABLE_DEPTH : count[r];
		endfunction

		function bit find_src(logic [15:0] id, output int p);
			for (int i = 0; i < limit(TBL_TRANS); i++)
				if (src_tab[i] == id) begin
					p = i;
					return 1'b1;
				end
			return 1'b0;
		endfunction

		// work out the answer for one accepted request and queue it
		function void note_request(req_t rq);
			answer_t a;
			int      p;
			int      n;
			int      l;
			bit      fwd;
			bit      rev;
			a = '0;
			p = 0;
			case (rq.op)
				OP_WRITE: begin
					case (rq.tbl)
						TBL_BAD:   a.bad = 1'b1;
						TBL_ATOM:  atom_tab[rq.idx] = rq.node[0];
						TBL_TRANS: begin
							src_tab[rq.idx] = rq.node[0];
							dst_tab[rq.idx] = rq.dest;
						end
						TBL_BOND, TBL_ANGLE, TBL_DIHED: begin
							l = rq.tbl - TBL_BOND + 2;
							key_tab[rq.tbl][rq.idx] = '0;
							for (int k = 0; k < l; k++)
								key_tab[rq.tbl][rq.idx][16*k +: 16] = rq.node[k];
						end
						default: ;
					endcase
				end
				OP_SELECT: begin
					case (rq.tbl)
						TBL_ATOM:
							for (int i = 0; i < limit(TBL_ATOM) && !a.found; i++)
								if (atom_tab[i] == rq.node[0]) begin
									a.found = 1'b1;
									a.pos = 6'(i);
								end
						TBL_TRANS:
							if (find_src(rq.node[0], p)) begin
								a.found = 1'b1;
								a.pos = 6'(p);
							end
						TBL_BOND, TBL_ANGLE, TBL_DIHED: begin
							l = rq.tbl - TBL_BOND + 2;
							for (int i = 0; i < limit(rq.tbl) && !a.found; i++) begin
								fwd = 1'b1;
								rev = 1'b1;
								for (int k = 0; k < l; k++) begin
									if (key_tab[rq.tbl][i][16*k +: 16] != rq.node[k]) fwd = 1'b0;
									if (key_tab[rq.tbl][i][16*k +: 16] != rq.node[l-1-k]) rev = 1'b0;
								end
								if (fwd || rev) begin
									a.found = 1'b1;
									a.pos = 6'(i);
								end
							end
						end
						TBL_INDEX:
							if (rq.node[0] < TABLE_DEPTH) begin
								a.found = 1'b1;
								a.pos = rq.node[0][5:0];
							end
						TBL_BAD: a.bad = 1'b1;
						default: ;
					endcase
				end
				OP_TRANSLATE: begin
					n = (rq.len > 4) ? 4 : rq.len;
					a.out_a = rq.node[0];
					a.out_b = rq.node[1];
					a.out_c = rq.node[2];
					a.out_d = rq.node[3];
					if (n > 0 && find_src(rq.node[0], p)) a.out_a = dst_tab[p];
					if (n > 1 && find_src(rq.node[1], p)) a.out_b = dst_tab[p];
					if (n > 2 && find_src(rq.node[2], p)) a.out_c = dst_tab[p];
					if (n > 3 && find_src(rq.node[3], p)) a.out_d = dst_tab[p];
				end
				default: ;
			endcase
			owed.push_back(a);
		endfunction

		// compare one result beat with the oldest owed answer
		function void check_answer(answer_t got);
			answer_t want;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat %h", got);
				return;
			end
			want = owed.pop_front();
			if (got.found !== want.found || got.pos !== want.pos || got.bad !== want.bad ||
					got.out_a !== want.out_a || got.out_b !== want.out_b ||
					got.out_c !== want.out_c || got.out_d !== want.out_d) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: found %b/%b pos %0d/%0d bad %b/%b out %h/%h",
						want.found, got.found, want.pos, got.pos, want.bad, got.bad,
						{want.out_d, want.out_c, want.out_b, want.out_a},
						{got.out_d, got.out_c, got.out_b, got.out_a});
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic [4:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [6:0]  cfg_data;

	lookup_scoreboard sb;
	bit               no_idle;
	int               idle_cycles;

	force_field_tuple_lookup_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 0;
	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: random stalls, check each accepted beat
	initial begin
		answer_t got;
		m_tready = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			int stall;
			stall = no_idle ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				m_tready <= 0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			got = '0;
			got.found = m_tuser[0];
			got.bad   = m_tuser[1];
			got.pos   = m_tdata[5:0];
			got.out_a = m_tdata[21:6];
			got.out_b = m_tdata[37:22];
			got.out_c = m_tdata[53:38];
			got.out_d = m_tdata[69:54];
			sb.check_answer(got);
			@(negedge clk);
		end
	end

	// send one request beat after a random gap
	task automatic send(req_t rq);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {7'b0, rq.len, rq.dest, rq.node[3], rq.node[2], rq.node[1], rq.node[0],
			rq.idx};
		s_tuser  <= {rq.tbl, rq.op};
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		sb.note_request(rq);
		@(negedge clk);
	endtask

	// one register write, then the write enable is dropped again
	task automatic write_reg(logic [2:0] r, int v);
		cfg_we    <= 1;
		cfg_index <= r;
		cfg_data  <= v[6:0];
		@(negedge clk);
		cfg_we    <= 0;
		sb.set_count(r, v);
		@(negedge clk);
	endtask

	// hold stimulus until every owed answer has arrived, then let the unit settle
	task automatic drain();
		s_tvalid <= 0;
		while (sb.owed.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_id();
		return ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 7)) : 16'($urandom());
	endfunction

	function automatic req_t make_req(logic [1:0] op, logic [2:0] tbl);
		req_t rq;
		rq.op   = op;
		rq.tbl  = tbl;
		rq.idx  = 6'($urandom_range(0, 63));
		foreach (rq.node[k]) rq.node[k] = pick_id();
		rq.dest = 16'($urandom());
		rq.len  = 3'($urandom_range(0, 7));
		return rq;
	endfunction

	// random request; many lookups reuse a stored key, each id from its forward or reversed place
	function automatic req_t rand_req();
		req_t        rq;
		int          r;
		int          e;
		int          l;
		logic [63:0] key;
		logic [1:0]  op;
		r = $urandom_range(0, 99);
		if (r < 30) op = OP_WRITE;
		else if (r < 70) op = OP_SELECT;
		else if (r < 95) op = OP_TRANSLATE;
		else op = OP_NONE;
		rq = make_req(op, 3'($urandom_range(0, 7)));
		if (op == OP_SELECT && rq.tbl >= TBL_BOND && rq.tbl <= TBL_DIHED &&
				$urandom_range(0, 1)) begin
			l = rq.tbl - TBL_BOND + 2;
			e = $urandom_range(0, 63);
			key = sb.key_tab[rq.tbl][e];
			for (int k = 0; k < l; k++)
				rq.node[k] = $urandom_range(0, 1) ? key[16*k +: 16] : key[16*(l-1-k) +: 16];
		end
		return rq;
	endfunction

	initial begin
		req_t rq;
		int   v;
		sb        = new();
		no_idle   = 0;
		arst_n    = 0;
		s_tvalid  = 0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_we    = 0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: bad table, unknown opcode, index bounds, impropers, translate lengths
		send(make_req(OP_WRITE, TBL_BAD));
		send(make_req(OP_SELECT, TBL_BAD));
		send(make_req(OP_NONE, TBL_ATOM));
		send(make_req(OP_WRITE, TBL_IMPR));
		send(make_req(OP_WRITE, TBL_INDEX));
		send(make_req(OP_SELECT, TBL_IMPR));
		foreach (rq.node[k]) rq.node[k] = 16'hFFFF;
		rq.op = OP_SELECT;
		rq.tbl = TBL_INDEX;
		rq.idx = 6'd63;
		rq.dest = 16'hFFFF;
		rq.len = 3'd7;
		send(rq);
		rq.node[0] = 16'd63;
		send(rq);
		rq.node[0] = 16'd64;
		send(rq);
		rq.node[0] = 16'd0;
		send(rq);
		for (int t = TBL_ATOM; t <= TBL_DIHED; t++) send(make_req(OP_SELECT, 3'(t)));
		for (int n = 0; n < 6; n++) begin
			rq = make_req(OP_TRANSLATE, TBL_ATOM);
			rq.len = (n == 5) ? 3'd7 : 3'(n);
			send(rq);
		end

		// fill every entry of every table so any count reads written entries
		for (int t = TBL_ATOM; t <= TBL_DIHED; t++)
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				rq = make_req(OP_WRITE, 3'(t));
				rq.idx = 6'(i);
				send(rq);
			end

		// phases of random traffic under different counts
		for (int ph = 0; ph < 7; ph++) begin
			drain();
			for (int r = REG_ATOM_CNT; r <= REG_DIHED_CNT; r++) begin
				case (ph)
					0: v = TABLE_DEPTH;
					1: v = 0;
					2: v = 127;
					3: v = 1;
					default: v = $urandom_range(0, 3) == 0 ? 127 : $urandom_range(0, 64);
				endcase
				write_reg(3'(r), v);
			end
			for (int n = 0; n < 100; n++) begin
				if (n % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
				send(rand_req());
			end
		end
		no_idle = 0;
		s_tvalid <= 0;

		while (sb.owed.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (sb.errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: sim.f
sv/ffl_pkg.sv
sv/ffl_ram.sv
sv/ffl_lane.sv
sv/ffl_merge.sv
sv/force_field_tuple_lookup_unit.sv
tb/tb_top.sv
